// ===== sv/irefit_pkg.sv =====
// Shared types, codes and constant tables for the ion range fit block.
// Holds the fit coefficients in Q8.20 and the square-root table for 2^f.
// No dependencies.
package irefit_pkg;

  localparam int unsigned ENERGY_FRAC_BITS = 12;
  localparam int unsigned LOG_STEPS        = 20;
  localparam int unsigned HORNER_STEPS     = 4;
  localparam int unsigned POW_STEPS        = 20;
  localparam int unsigned NUM_COEF         = 5;
  localparam int unsigned NUM_SETS         = 9;

  localparam logic [28:0] LOG10_OF_2_Q30 = 29'd323228497;
  localparam logic [29:0] LOG2_OF_10_Q28 = 30'd891723283;

  localparam logic [6:0] ELEM_XE = 7'd54;
  localparam logic [6:0] ELEM_CS = 7'd55;
  localparam logic [6:0] ELEM_KR = 7'd36;

  localparam logic [1:0] FUEL_MAX = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ELEM = 2'd1,
    ST_ZERO     = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef struct packed {
    logic    vld;
    status_e sts;
    logic    fin;
    logic [3:0] set;
  } ctl_t;

  typedef logic signed [27:0] coef_t;
  typedef logic [NUM_SETS*NUM_COEF-1:0][27:0] coef_tab_t;

  localparam coef_t ACC_MAX = 28'sh7FFFFFF;
  localparam coef_t ACC_MIN = 28'sh8000000;

  localparam int COEF_E5 [NUM_SETS*NUM_COEF] = '{
    -567, 10018, -55072, 157743, -74034,
    -631, 10921, -58890, 169355, -98078,
    -567,  9466, -48892, 148024, -85407,
    -412,  7050, -36317, 118349, -74233,
    -587,  9994, -51886, 147940, -87568,
    -513,  8295, -39975, 120048, -65063,
    -454,  7926, -42869, 138063, -84672,
    -634, 10921, -58467, 166738, -95908,
    -569,  9428, -48186, 144725, -82760
  };

  function automatic coef_t to_q20(int k);
    longint v;
    longint mag;
    longint r;
    v   = longint'(k) * 64'sd1048576;
    mag = (v < 0) ? -v : v;
    r   = (mag + 64'sd50000) / 64'sd100000;
    return coef_t'((v < 0) ? -r : r);
  endfunction

  function automatic coef_tab_t build_coef();
    coef_tab_t t;
    for (int i = 0; i < NUM_SETS*NUM_COEF; i++) begin
      t[i] = to_q20(COEF_E5[i]);
    end
    return t;
  endfunction

  localparam coef_tab_t COEF_Q20 = build_coef();

  function automatic coef_t coef_at(logic [3:0] set, logic [2:0] idx);
    logic [5:0] a;
    a = 6'(set) * 6'd5 + 6'(idx);
    return coef_t'(COEF_Q20[a]);
  endfunction

  function automatic logic [31:0] root_at(int k);
    longint unsigned r;
    longint unsigned v;
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bv;
    r = 64'd1 << 31;
    for (int j = 1; j <= k; j++) begin
      v   = r << 30;
      rem = v;
      res = 64'd0;
      bv  = 64'd1 << 62;
      for (int s = 0; s < 32; s++) begin
        if (rem >= res + bv) begin
          rem = rem - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      if (res * res + res < v) begin
        res = res + 64'd1;
      end
      r = res;
    end
    return r[31:0];
  endfunction

endpackage

// ===== sv/irefit_log_cell.sv =====
// One squaring cell of the log2 mantissa chain: yields one fraction bit.
// Depends on irefit_pkg.
module irefit_log_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  irefit_pkg::ctl_t   ctl_i,
  input  logic [30:0]        m_i,
  input  logic [19:0]        frac_i,
  input  logic [4:0]         pos_i,
  output irefit_pkg::ctl_t   ctl_o,
  output logic [30:0]        m_o,
  output logic [19:0]        frac_o,
  output logic [4:0]         pos_o
);

  logic [61:0] sq;
  logic        b;
  logic [30:0] m_d;

  always_comb begin
    sq  = 62'(m_i) * 62'(m_i);
    b   = sq[61];
    m_d = b ? sq[61:31] : sq[60:30];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m_o    <= m_d;
    frac_o <= {frac_i[18:0], b};
    pos_o  <= pos_i;
  end

endmodule

// ===== sv/irefit_horner_cell.sv =====
// One Horner step: acc * x rounded, plus the next coefficient, clamped.
// Depends on irefit_pkg for the coefficient table.
module irefit_horner_cell #(
  parameter int unsigned IDX = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  irefit_pkg::ctl_t        ctl_i,
  input  irefit_pkg::coef_t       acc_i,
  input  logic signed [24:0]      x_i,
  output irefit_pkg::ctl_t        ctl_o,
  output irefit_pkg::coef_t       acc_o,
  output logic signed [24:0]      x_o
);

  logic signed [52:0] prod;
  logic [52:0]        mag;
  logic [32:0]        rnd;
  logic signed [34:0] sum;
  irefit_pkg::coef_t  c;
  irefit_pkg::coef_t  acc_d;

  always_comb begin
    c    = irefit_pkg::coef_at(ctl_i.set, 3'(IDX));
    prod = acc_i * x_i;
    mag  = prod[52] ? 53'(-prod) : 53'(prod);
    rnd  = 33'((mag + (53'(1) << 19)) >> 20);
    sum  = (prod[52] ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd})) + 35'(c);
    if (sum > 35'(irefit_pkg::ACC_MAX)) begin
      acc_d = irefit_pkg::ACC_MAX;
    end else if (sum < 35'(irefit_pkg::ACC_MIN)) begin
      acc_d = irefit_pkg::ACC_MIN;
    end else begin
      acc_d = 28'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_o <= acc_d;
    x_o   <= x_i;
  end

endmodule

// ===== sv/irefit_pow_cell.sv =====
// One cell of the 2^f chain: multiply by a fixed root of two when its bit is set.
// Depends on irefit_pkg for the root table.
module irefit_pow_cell #(
  parameter int unsigned K = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  irefit_pkg::ctl_t   ctl_i,
  input  logic [31:0]        p_i,
  input  logic [19:0]        f_i,
  input  logic signed [5:0]  n_i,
  output irefit_pkg::ctl_t   ctl_o,
  output logic [31:0]        p_o,
  output logic [19:0]        f_o,
  output logic signed [5:0]  n_o
);

  localparam logic [31:0] ROOT = irefit_pkg::root_at(K);
  localparam int unsigned BITI = irefit_pkg::POW_STEPS - K;

  logic [63:0] prod;
  logic [63:0] pr;

  always_comb begin
    prod = 64'(p_i) * 64'(ROOT);
    pr   = (prod + (64'd1 << 29)) >> 30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= f_i[BITI] ? pr[31:0] : p_i;
    f_o <= f_i;
    n_o <= n_i;
  end

endmodule

// ===== sv/ion_range_energy_fit.sv =====
// Top level of the ion range fit: APB register, front end, cell chains, back end.
// Depends on irefit_pkg, irefit_log_cell, irefit_horner_cell, irefit_pow_cell.
//
// Usage: a request (element_i, energy_i) is taken at each clock edge with start_i
// high; busy_o stays low, so one request enters every cycle. The result sits on
// range_o and status_o for one cycle with done_o high. Between the request and done_o
// lie one front stage, 20 log cells (one squaring each), the log10 scaling stage,
// 4 Horner cells, two exponent stages, 20 power cells (one root multiply each) and
// the output register.
// Throughput is one result per cycle, in request order.
// fuel_kind sits at APB address 0; write it only while no request is in flight.
// Reset clears fuel_kind to carbide and drops every request in flight. The
// receiver cannot stall: a result is shown for exactly one cycle.
module ion_range_energy_fit #(
  parameter int unsigned ENERGY_FRAC_BITS = irefit_pkg::ENERGY_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [6:0]  element_i,
  input  logic [31:0] energy_i,
  output logic        done_o,
  output logic [31:0] range_o,
  output logic [1:0]  status_o
);

  localparam int unsigned NL = irefit_pkg::LOG_STEPS;
  localparam int unsigned NH = irefit_pkg::HORNER_STEPS;
  localparam int unsigned NP = irefit_pkg::POW_STEPS;
  localparam int unsigned LATENCY = 5 + NL + NH + NP;

  logic [1:0] fuel_q;

  assign pready = 1'b1;
  assign prdata = {30'd0, fuel_q};
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fuel_q <= 2'd0;
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      fuel_q <= pwdata[1:0];
    end
  end

  // front end
  logic              bad;
  logic [1:0]        slot;
  logic [4:0]        pos;
  logic [61:0]       wide;
  irefit_pkg::ctl_t  ctl0_d;

  always_comb begin
    bad  = 1'b0;
    slot = 2'd0;
    case (element_i)
      irefit_pkg::ELEM_XE: slot = 2'd0;
      irefit_pkg::ELEM_CS: slot = 2'd1;
      irefit_pkg::ELEM_KR: slot = 2'd2;
      default:             bad  = 1'b1;
    endcase
    if (fuel_q > irefit_pkg::FUEL_MAX) begin
      bad = 1'b1;
    end
    pos = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (energy_i[i]) begin
        pos = 5'(i);
      end
    end
    wide       = (62'(energy_i) << 30) >> pos;
    ctl0_d.vld = start_i && !busy_o;
    ctl0_d.set = bad ? 4'd0 : 4'(4'(fuel_q) * 4'd3 + 4'(slot));
    if (bad) begin
      ctl0_d.sts = irefit_pkg::ST_BAD_ELEM;
      ctl0_d.fin = 1'b1;
    end else if (energy_i == 32'd0) begin
      ctl0_d.sts = irefit_pkg::ST_ZERO;
      ctl0_d.fin = 1'b1;
    end else begin
      ctl0_d.sts = irefit_pkg::ST_OK;
      ctl0_d.fin = 1'b0;
    end
  end

  irefit_pkg::ctl_t lctl [NL+1];
  logic [30:0]      lm   [NL+1];
  logic [19:0]      lfr  [NL+1];
  logic [4:0]       lpos [NL+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lctl[0] <= '0;
    end else begin
      lctl[0] <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lm[0]   <= wide[30:0];
    lfr[0]  <= 20'd0;
    lpos[0] <= pos;
  end

  for (genvar g = 0; g < NL; g++) begin : g_log
    irefit_log_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lctl[g]),
      .m_i    (lm[g]),
      .frac_i (lfr[g]),
      .pos_i  (lpos[g]),
      .ctl_o  (lctl[g+1]),
      .m_o    (lm[g+1]),
      .frac_o (lfr[g+1]),
      .pos_o  (lpos[g+1])
    );
  end

  // log10 scaling
  logic signed [6:0]  dexp;
  logic signed [26:0] l2;
  logic signed [56:0] xprod;
  logic [56:0]        xmag;
  logic [26:0]        xr;
  logic signed [24:0] x_d;

  always_comb begin
    dexp  = $signed({2'b00, lpos[NL]}) - $signed(7'(ENERGY_FRAC_BITS));
    l2    = $signed({dexp, lfr[NL]});
    xprod = l2 * $signed({1'b0, irefit_pkg::LOG10_OF_2_Q30});
    xmag  = xprod[56] ? 57'(-xprod) : 57'(xprod);
    xr    = 27'((xmag + (57'(1) << 29)) >> 30);
    x_d   = xprod[56] ? -$signed(25'(xr)) : $signed(25'(xr));
  end

  irefit_pkg::ctl_t   hctl [NH+1];
  irefit_pkg::coef_t  hacc [NH+1];
  logic signed [24:0] hx   [NH+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hctl[0] <= '0;
    end else begin
      hctl[0] <= lctl[NL];
    end
  end

  always_ff @(posedge clk_i) begin
    hacc[0] <= irefit_pkg::coef_at(lctl[NL].set, 3'd0);
    hx[0]   <= x_d;
  end

  for (genvar g = 0; g < NH; g++) begin : g_horner
    irefit_horner_cell #(.IDX(g + 1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (hctl[g]),
      .acc_i  (hacc[g]),
      .x_i    (hx[g]),
      .ctl_o  (hctl[g+1]),
      .acc_o  (hacc[g+1]),
      .x_o    (hx[g+1])
    );
  end

  // exponent: y = L * log2(10)
  logic signed [58:0] yprod;
  logic [58:0]        ymag;
  logic [30:0]        yr;
  logic signed [31:0] y_d;
  logic signed [31:0] y_q;
  irefit_pkg::ctl_t   yctl_q;

  always_comb begin
    yprod = hacc[NH] * $signed({1'b0, irefit_pkg::LOG2_OF_10_Q28});
    ymag  = yprod[58] ? 59'(-yprod) : 59'(yprod);
    yr    = 31'((ymag + (59'(1) << 27)) >> 28);
    y_d   = yprod[58] ? -$signed(32'(yr)) : $signed(32'(yr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yctl_q <= '0;
    end else begin
      yctl_q <= hctl[NH];
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  // split t into integer and fraction
  logic signed [32:0] t;
  logic signed [12:0] nn;
  irefit_pkg::ctl_t   tctl_d;

  always_comb begin
    t      = $signed(33'(y_q)) + 33'sh1000000;
    nn     = 13'(t >>> 20);
    tctl_d = yctl_q;
    if (!yctl_q.fin) begin
      if (t >= 33'sh2000000) begin
        tctl_d.sts = irefit_pkg::ST_SAT;
        tctl_d.fin = 1'b1;
      end else if (nn < -13'sd1) begin
        tctl_d.sts = irefit_pkg::ST_OK;
        tctl_d.fin = 1'b1;
      end
    end
  end

  irefit_pkg::ctl_t  pctl [NP+1];
  logic [31:0]       pp   [NP+1];
  logic [19:0]       pf   [NP+1];
  logic signed [5:0] pn   [NP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctl[0] <= '0;
    end else begin
      pctl[0] <= tctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp[0] <= 32'd1 << 30;
    pf[0] <= t[19:0];
    pn[0] <= 6'(nn);
  end

  for (genvar g = 0; g < NP; g++) begin : g_pow
    irefit_pow_cell #(.K(g + 1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (pctl[g]),
      .p_i    (pp[g]),
      .f_i    (pf[g]),
      .n_i    (pn[g]),
      .ctl_o  (pctl[g+1]),
      .p_o    (pp[g+1]),
      .f_o    (pf[g+1]),
      .n_o    (pn[g+1])
    );
  end

  // scale to Q16.16 and saturate
  logic [5:0]           sh;
  logic [34:0]          half;
  logic [34:0]          res;
  logic [31:0]          range_d;
  irefit_pkg::status_e  sts_d;

  always_comb begin
    sh   = 6'(6'sd31 - pn[NP]);
    half = (sh == 6'd0) ? 35'd0 : (35'd1 << (sh - 6'd1));
    res  = (35'({pp[NP], 1'b0}) + half) >> sh;
    if (pctl[NP].fin) begin
      sts_d   = pctl[NP].sts;
      range_d = (pctl[NP].sts == irefit_pkg::ST_SAT) ? 32'hFFFFFFFF : 32'd0;
    end else if (res > 35'h0FFFFFFFF) begin
      sts_d   = irefit_pkg::ST_SAT;
      range_d = 32'hFFFFFFFF;
    end else begin
      sts_d   = irefit_pkg::ST_OK;
      range_d = res[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= pctl[NP].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    range_o  <= range_d;
    status_o <= sts_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("request did not complete after the pipeline latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == irefit_pkg::ST_SAT) |-> (range_o == 32'hFFFFFFFF))
    else $error("saturated result without full-scale range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == irefit_pkg::ST_BAD_ELEM || status_o == irefit_pkg::ST_ZERO))
      |-> (range_o == 32'd0))
    else $error("error result with nonzero range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hctl[0].vld && hctl[0].fin) |-> ##(NH + 3 + NP) (done_o && status_o != irefit_pkg::ST_OK
      || done_o && range_o == 32'd0))
    else $error("early-finished request lost its fixed result");

endmodule
